/* design/aalve_pkg.sv */
// ----------------------------------------------------------------------------
// aalve_pkg
// Shared constants for the antialiased hairline vertex expander: vertex
// numbering within one segment.
// ----------------------------------------------------------------------------
package aalve_pkg;

  localparam int VTX_IDX_W = 3;

  // vertex order: two inner, then four outer
  localparam logic [VTX_IDX_W-1:0] VTX_INNER0 = 3'd0;
  localparam logic [VTX_IDX_W-1:0] VTX_INNER1 = 3'd1;
  localparam logic [VTX_IDX_W-1:0] VTX_OUT_AP = 3'd2;  // a - h + o
  localparam logic [VTX_IDX_W-1:0] VTX_OUT_BP = 3'd3;  // b + h + o
  localparam logic [VTX_IDX_W-1:0] VTX_OUT_AN = 3'd4;  // a - h - o
  localparam logic [VTX_IDX_W-1:0] VTX_OUT_BN = 3'd5;  // b + h - o
  localparam logic [VTX_IDX_W-1:0] VTX_LAST   = VTX_OUT_BN;

endpackage

/* design/aa_line_vertex_expand.sv */
// ----------------------------------------------------------------------------
// aa_line_vertex_expand
// Expands one line segment into six antialiasing vertices with coverage.
//
//   channel | direction | words                                   | handshake
//   in_     | input     | one segment (start_x/y, end_x/y)        | valid/stall
//   out_    | output    | six vertices per segment, last on sixth | valid/stall
//
// A segment passes 5 + (2*COORD_FRAC_BITS+1) + max(F,C)+1 register stages
// (restoring divider, then square root search, one bit per stage), the last
// of them the output register, which hands out one vertex word per cycle
// unless out_stall holds it. The whole pipeline holds while the output
// register is busy and moves once its last word is taken. Reset (rst_n
// low, synchronous) empties all stages. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module aa_line_vertex_expand
  import aalve_pkg::*;
#(
  parameter int COORD_BITS         = 24,
  parameter int COORD_FRAC_BITS    = 8,
  parameter int COVERAGE_FRAC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_BITS-1:0]    in_start_x,
  input  logic signed [COORD_BITS-1:0]    in_start_y,
  input  logic signed [COORD_BITS-1:0]    in_end_x,
  input  logic signed [COORD_BITS-1:0]    in_end_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [VTX_IDX_W-1:0]            out_vertex_index,
  output logic signed [COORD_BITS-1:0]    out_vertex_x,
  output logic signed [COORD_BITS-1:0]    out_vertex_y,
  output logic [COVERAGE_FRAC_BITS:0]     out_coverage,
  output logic                            out_degenerate,
  output logic                            out_last
);

  localparam int CW  = COORD_BITS;
  localparam int F   = COORD_FRAC_BITS;
  localparam int C   = COVERAGE_FRAC_BITS;
  localparam int MW  = CW + 1;             // |d| up to 2^CW - 1
  localparam int SQW = 2 * MW;
  localparam int L2W = SQW + 1;
  localparam int QW  = 2 * F + 1;          // quotient mag^2*2^2F/L2 <= 2^2F
  localparam int NW  = SQW + 2 * F + 1;    // divider remainder width
  localparam int PW  = 2 * C + 2;          // scaled short length squared
  localparam int RS  = (F > C) ? F + 1 : C + 1;  // root bits
  localparam int SW  = 2 * RS;
  localparam int VW  = CW + 3;             // unsaturated vertex sum
  localparam int CVW = C + 1;

  localparam logic signed [VW-1:0] V_MAX =
    $signed({{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [VW-1:0] V_MIN = ~V_MAX;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic                 neg_x;
    logic                 neg_y;
    logic                 short_seg;
    logic                 degen;
  } seg_t;

  function automatic logic signed [CW-1:0] sat(input logic signed [VW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > V_MAX)      r = CW'(V_MAX);
    else if (v < V_MIN) r = CW'(V_MIN);
    else                r = CW'(v);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // pipeline advance: everything moves unless the output register is busy
  logic en;
  logic out_take;
  logic emit_valid_r;
  logic [VTX_IDX_W-1:0] k_r;

  assign out_take = emit_valid_r && !out_stall;
  assign en       = !emit_valid_r || (out_take && (k_r == VTX_LAST));
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // stage 1: register endpoints, difference magnitudes
  logic          s1_v_r;
  seg_t          s1_seg_r, s1_seg_nxt;
  logic [MW-1:0] s1_mx_r, s1_my_r, s1_mx_nxt, s1_my_nxt;

  always_comb begin
    logic signed [MW-1:0] dx, dy;
    dx = MW'(in_end_x) - MW'(in_start_x);
    dy = MW'(in_end_y) - MW'(in_start_y);
    s1_seg_nxt.ax        = in_start_x;
    s1_seg_nxt.ay        = in_start_y;
    s1_seg_nxt.bx        = in_end_x;
    s1_seg_nxt.by        = in_end_y;
    s1_seg_nxt.neg_x     = dx[MW-1];
    s1_seg_nxt.neg_y     = dy[MW-1];
    s1_seg_nxt.short_seg = 1'b0;
    s1_seg_nxt.degen     = (dx == '0) && (dy == '0);
    s1_mx_nxt = dx[MW-1] ? MW'(-dx) : MW'(dx);
    s1_my_nxt = dy[MW-1] ? MW'(-dy) : MW'(dy);
  end

  // stage 2: squares
  logic           s2_v_r;
  seg_t           s2_seg_r;
  logic [SQW-1:0] s2_sqx_r, s2_sqy_r;

  // --------------------------------------------------------------------------
  // divider stages: index 0 holds L2 and numerators, each later stage
  // resolves one quotient bit, MSB first
  logic           dv_v_r   [QW+1];
  seg_t           dv_seg_r [QW+1];
  logic [L2W-1:0] dv_l2_r  [QW+1];
  logic [NW-1:0]  dv_rx_r  [QW+1];
  logic [NW-1:0]  dv_ry_r  [QW+1];
  logic [QW-1:0]  dv_qx_r  [QW+1];
  logic [QW-1:0]  dv_qy_r  [QW+1];
  logic [PW-1:0]  dv_p_r   [QW+1];

  seg_t           dv0_seg_nxt;
  logic [L2W-1:0] dv0_l2_nxt;
  logic [PW-1:0]  dv0_p_nxt;

  always_comb begin
    logic [L2W+PW-1:0] pwide;
    dv0_l2_nxt = L2W'(s2_sqx_r) + L2W'(s2_sqy_r);
    pwide      = (L2W+PW)'(dv0_l2_nxt) << (2 * C + 2);
    dv0_p_nxt  = PW'(pwide >> (2 * F));
    dv0_seg_nxt = s2_seg_r;
    dv0_seg_nxt.short_seg = dv0_l2_nxt < (L2W'(1) << (2 * F));
  end

  logic [NW-1:0] dv_rx_nxt [QW];
  logic [NW-1:0] dv_ry_nxt [QW];
  logic [QW-1:0] dv_qx_nxt [QW];
  logic [QW-1:0] dv_qy_nxt [QW];

  // one restoring division step per stage, for both components
  always_comb begin
    logic [NW-1:0] dcmp;
    for (int i = 0; i < QW; i++) begin
      dcmp = NW'(dv_l2_r[i]) << (QW - 1 - i);
      dv_rx_nxt[i] = dv_rx_r[i];
      dv_qx_nxt[i] = dv_qx_r[i];
      dv_ry_nxt[i] = dv_ry_r[i];
      dv_qy_nxt[i] = dv_qy_r[i];
      if (dv_rx_r[i] >= dcmp) begin
        dv_rx_nxt[i] = dv_rx_r[i] - dcmp;
        dv_qx_nxt[i] = dv_qx_r[i] | (QW'(1) << (QW - 1 - i));
      end
      if (dv_ry_r[i] >= dcmp) begin
        dv_ry_nxt[i] = dv_ry_r[i] - dcmp;
        dv_qy_nxt[i] = dv_qy_r[i] | (QW'(1) << (QW - 1 - i));
      end
    end
  end

  // --------------------------------------------------------------------------
  // square root stages: one root bit per stage for both quotients and for
  // the scaled short length
  logic           sq_v_r   [RS+1];
  seg_t           sq_seg_r [RS+1];
  logic [QW-1:0]  sq_qx_r  [RS+1];
  logic [QW-1:0]  sq_qy_r  [RS+1];
  logic [PW-1:0]  sq_p_r   [RS+1];
  logic [RS-1:0]  sq_rx_r  [RS+1];
  logic [RS-1:0]  sq_ry_r  [RS+1];
  logic [RS-1:0]  sq_rp_r  [RS+1];

  logic [RS-1:0]  sq_rx_nxt [RS];
  logic [RS-1:0]  sq_ry_nxt [RS];
  logic [RS-1:0]  sq_rp_nxt [RS];

  always_comb begin
    logic [RS-1:0] cx, cy, cp;
    for (int j = 0; j < RS; j++) begin
      cx = sq_rx_r[j] | (RS'(1) << (RS - 1 - j));
      cy = sq_ry_r[j] | (RS'(1) << (RS - 1 - j));
      cp = sq_rp_r[j] | (RS'(1) << (RS - 1 - j));
      sq_rx_nxt[j] = ((SW'(cx) * SW'(cx)) <= SW'(sq_qx_r[j])) ? cx : sq_rx_r[j];
      sq_ry_nxt[j] = ((SW'(cy) * SW'(cy)) <= SW'(sq_qy_r[j])) ? cy : sq_ry_r[j];
      sq_rp_nxt[j] = ((SW'(cp) * SW'(cp)) <= SW'(sq_p_r[j]))  ? cp : sq_rp_r[j];
    end
  end

  // --------------------------------------------------------------------------
  // vertex build: half vector, orthogonal offset, six saturated vertices
  logic signed [CW-1:0] vx_nxt [6];
  logic signed [CW-1:0] vy_nxt [6];
  logic [CVW-1:0]       cov_nxt;

  always_comb begin
    seg_t                 sg;
    logic [RS:0]          tx, ty, tp;
    logic signed [VW-1:0] hx, hy, ox, oy, ax, ay, bx, by;
    sg = sq_seg_r[RS];
    tx = (RS+1)'(sq_rx_r[RS]) + (RS+1)'(1);
    ty = (RS+1)'(sq_ry_r[RS]) + (RS+1)'(1);
    tp = (RS+1)'(sq_rp_r[RS]) + (RS+1)'(1);
    hx = $signed(VW'(tx[RS:1]));
    hy = $signed(VW'(ty[RS:1]));
    if (sg.neg_x) hx = -hx;
    if (sg.neg_y) hy = -hy;
    ox = hy + hy;
    oy = -(hx + hx);
    ax = VW'(sg.ax);
    ay = VW'(sg.ay);
    bx = VW'(sg.bx);
    by = VW'(sg.by);
    cov_nxt = sg.short_seg ? CVW'(tp[RS:1]) : (CVW'(1) << C);
    // short segments swap the inner pair
    if (sg.short_seg) begin
      vx_nxt[VTX_INNER0] = sat(bx - hx);
      vy_nxt[VTX_INNER0] = sat(by - hy);
      vx_nxt[VTX_INNER1] = sat(ax + hx);
      vy_nxt[VTX_INNER1] = sat(ay + hy);
    end else begin
      vx_nxt[VTX_INNER0] = sat(ax + hx);
      vy_nxt[VTX_INNER0] = sat(ay + hy);
      vx_nxt[VTX_INNER1] = sat(bx - hx);
      vy_nxt[VTX_INNER1] = sat(by - hy);
    end
    vx_nxt[VTX_OUT_AP] = sat(ax - hx + ox);
    vy_nxt[VTX_OUT_AP] = sat(ay - hy + oy);
    vx_nxt[VTX_OUT_BP] = sat(bx + hx + ox);
    vy_nxt[VTX_OUT_BP] = sat(by + hy + oy);
    vx_nxt[VTX_OUT_AN] = sat(ax - hx - ox);
    vy_nxt[VTX_OUT_AN] = sat(ay - hy - oy);
    vx_nxt[VTX_OUT_BN] = sat(bx + hx - ox);
    vy_nxt[VTX_OUT_BN] = sat(by + hy - oy);
    // zero length: everything at the origin, no coverage
    if (sg.degen) begin
      cov_nxt = '0;
      for (int k = 0; k < 6; k++) begin
        vx_nxt[k] = '0;
        vy_nxt[k] = '0;
      end
    end
  end

  // output register: one segment, walked one vertex word per cycle unless stalled
  logic signed [CW-1:0] vx_r [6];
  logic signed [CW-1:0] vy_r [6];
  logic [CVW-1:0]       cov_r;
  logic                 degen_r;

  // --------------------------------------------------------------------------
  // valid bits and output counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      emit_valid_r <= 1'b0;
      k_r          <= VTX_INNER0;
      for (int i = 0; i <= QW; i++) dv_v_r[i] <= 1'b0;
      for (int j = 0; j <= RS; j++) sq_v_r[j] <= 1'b0;
    end else if (en) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      dv_v_r[0] <= s2_v_r;
      for (int i = 0; i < QW; i++) dv_v_r[i+1] <= dv_v_r[i];
      sq_v_r[0] <= dv_v_r[QW];
      for (int j = 0; j < RS; j++) sq_v_r[j+1] <= sq_v_r[j];
      emit_valid_r <= sq_v_r[RS];
      k_r          <= VTX_INNER0;
    end else if (out_take) begin
      k_r <= k_r + VTX_IDX_W'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_seg_r <= s1_seg_nxt;
      s1_mx_r  <= s1_mx_nxt;
      s1_my_r  <= s1_my_nxt;

      s2_seg_r <= s1_seg_r;
      s2_sqx_r <= SQW'(s1_mx_r) * SQW'(s1_mx_r);
      s2_sqy_r <= SQW'(s1_my_r) * SQW'(s1_my_r);

      dv_seg_r[0] <= dv0_seg_nxt;
      dv_l2_r[0]  <= dv0_l2_nxt;
      dv_rx_r[0]  <= NW'(s2_sqx_r) << (2 * F);
      dv_ry_r[0]  <= NW'(s2_sqy_r) << (2 * F);
      dv_qx_r[0]  <= '0;
      dv_qy_r[0]  <= '0;
      dv_p_r[0]   <= dv0_p_nxt;
      for (int i = 0; i < QW; i++) begin
        dv_seg_r[i+1] <= dv_seg_r[i];
        dv_l2_r[i+1]  <= dv_l2_r[i];
        dv_rx_r[i+1]  <= dv_rx_nxt[i];
        dv_ry_r[i+1]  <= dv_ry_nxt[i];
        dv_qx_r[i+1]  <= dv_qx_nxt[i];
        dv_qy_r[i+1]  <= dv_qy_nxt[i];
        dv_p_r[i+1]   <= dv_p_r[i];
      end

      sq_seg_r[0] <= dv_seg_r[QW];
      sq_qx_r[0]  <= dv_qx_r[QW];
      sq_qy_r[0]  <= dv_qy_r[QW];
      sq_p_r[0]   <= dv_p_r[QW];
      sq_rx_r[0]  <= '0;
      sq_ry_r[0]  <= '0;
      sq_rp_r[0]  <= '0;
      for (int j = 0; j < RS; j++) begin
        sq_seg_r[j+1] <= sq_seg_r[j];
        sq_qx_r[j+1]  <= sq_qx_r[j];
        sq_qy_r[j+1]  <= sq_qy_r[j];
        sq_p_r[j+1]   <= sq_p_r[j];
        sq_rx_r[j+1]  <= sq_rx_nxt[j];
        sq_ry_r[j+1]  <= sq_ry_nxt[j];
        sq_rp_r[j+1]  <= sq_rp_nxt[j];
      end

      for (int k = 0; k < 6; k++) begin
        vx_r[k] <= vx_nxt[k];
        vy_r[k] <= vy_nxt[k];
      end
      cov_r   <= cov_nxt;
      degen_r <= sq_seg_r[RS].degen;
    end
  end

  // --------------------------------------------------------------------------
  // output word
  assign out_valid        = emit_valid_r;
  assign out_vertex_index = k_r;
  assign out_vertex_x     = vx_r[k_r];
  assign out_vertex_y     = vy_r[k_r];
  assign out_coverage     = (k_r <= VTX_INNER1) ? cov_r : '0;
  assign out_degenerate   = degen_r;
  assign out_last         = (k_r == VTX_LAST);

  // --------------------------------------------------------------------------
  // checks
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_vertex_index == $past(out_vertex_index) + VTX_IDX_W'(1)))
    else $error("vertex walk skipped or stopped");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vertex_index <= VTX_LAST))
    else $error("vertex index out of range");

  a_outer_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_vertex_index > VTX_INNER1) |-> (out_coverage == '0))
    else $error("outer vertex carries coverage");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_vertex_x == '0) && (out_vertex_y == '0) && (out_coverage == '0))
    else $error("degenerate segment vertex not at origin");

endmodule

/* verif/tb_aa_line_vertex_expand.sv */
// ----------------------------------------------------------------------------
// tb_aa_line_vertex_expand
// Self-checking bench for the hairline vertex expander. Segments are queued,
// then sent in random bursts. The receiver stalls on its own pattern. Every
// segment is predicted as six vertex words, and each output word is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_aa_line_vertex_expand
  import aalve_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 24;
  localparam int FB = 8;
  localparam int CVB = 12;

  typedef struct packed {
    logic signed [CB-1:0] sx;
    logic signed [CB-1:0] sy;
    logic signed [CB-1:0] ex;
    logic signed [CB-1:0] ey;
  } segment_t;

  typedef struct packed {
    logic [VTX_IDX_W-1:0] idx;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [CVB:0]         cov;
    logic                 degen;
    logic                 last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VTX_IDX_W-1:0] out_vertex_index;
  logic signed [CB-1:0] out_vertex_x, out_vertex_y;
  logic [CVB:0] out_coverage;
  logic out_degenerate, out_last;

  segment_t pending_segs[$];
  vertex_t  vertex_fifo[$];
  int errors = 0;
  int segs_sent = 0;
  int words_seen = 0;
  int short_segs = 0;
  int degen_segs = 0;

  always #4 clk = ~clk;

  aa_line_vertex_expand u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .out_valid, .out_stall, .out_vertex_index, .out_vertex_x, .out_vertex_y,
    .out_coverage, .out_degenerate, .out_last
  );

  // round(2^(FB-1) * mag / sqrt(len2)), exact search
  function automatic longint half_step(longint unsigned mag, logic [127:0] len2);
    longint unsigned lo, hi, mid, t;
    logic [127:0] rhs, lhs;
    lo = 0;
    hi = 64'd1 << (FB - 1);
    rhs = (128'(mag) * 128'(mag)) << (2 * FB);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      lhs = len2 * 128'(t) * 128'(t);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  // coverage of a sub-pixel segment: round(sqrt(l2) * 2^(CVB-FB))
  function automatic longint unsigned short_cov(longint unsigned l2);
    longint unsigned lo, hi, mid, t;
    lo = 0;
    hi = 64'd1 << CVB;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (((128'(t) * 128'(t)) << (2 * FB)) <= (128'(l2) << (2 * CVB + 2))) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic signed [CB-1:0] clamp(longint v);
    longint top;
    top = (64'sd1 <<< (CB - 1)) - 1;
    if (v > top) return CB'(top);
    if (v < -top - 1) return CB'(-top - 1);
    return CB'(v);
  endfunction

  // build the six expected vertex words of one segment
  task automatic predict_vertices(segment_t s);
    longint ax, ay, bx, by, dx, dy, hx, hy, ox, oy;
    longint vx[6], vy[6];
    longint unsigned mx, my, cov;
    logic [127:0] len2;
    logic degen, is_short;
    vertex_t v;
    ax = s.sx; ay = s.sy; bx = s.ex; by = s.ey;
    dx = bx - ax;
    dy = by - ay;
    cov = 0;
    degen = 1'b0;
    if (dx == 0 && dy == 0) begin
      degen = 1'b1;
      degen_segs++;
      for (int k = 0; k < 6; k++) begin
        vx[k] = 0;
        vy[k] = 0;
      end
    end else begin
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      len2 = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
      hx = half_step(mx, len2);
      hy = half_step(my, len2);
      if (dx < 0) hx = -hx;
      if (dy < 0) hy = -hy;
      ox = 2 * hy;
      oy = -2 * hx;
      is_short = len2 < (128'd1 << (2 * FB));
      if (is_short) short_segs++;
      cov = is_short ? short_cov(64'(len2)) : (64'd1 << CVB);
      // sub-pixel segments swap the inner pair
      if (is_short) begin
        vx[0] = bx - hx; vy[0] = by - hy;
        vx[1] = ax + hx; vy[1] = ay + hy;
      end else begin
        vx[0] = ax + hx; vy[0] = ay + hy;
        vx[1] = bx - hx; vy[1] = by - hy;
      end
      vx[2] = ax - hx + ox; vy[2] = ay - hy + oy;
      vx[3] = bx + hx + ox; vy[3] = by + hy + oy;
      vx[4] = ax - hx - ox; vy[4] = ay - hy - oy;
      vx[5] = bx + hx - ox; vy[5] = by + hy - oy;
    end
    for (int k = 0; k < 6; k++) begin
      v.idx = VTX_IDX_W'(k);
      v.x = clamp(vx[k]);
      v.y = clamp(vy[k]);
      v.cov = (k < 2) ? (CVB + 1)'(cov) : '0;
      v.degen = degen;
      v.last = (VTX_IDX_W'(k) == VTX_LAST);
      vertex_fifo.insert(vertex_fifo.size(), v);
    end
  endtask

  // driver: bursts of segments with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    segment_t s;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        s = '{in_start_x, in_start_y, in_end_x, in_end_y};
        predict_vertices(s);
        segs_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_segs.size() > 0) begin
          s = pending_segs.pop_front();
          in_start_x <= s.sx;
          in_start_y <= s.sy;
          in_end_x <= s.ex;
          in_end_y <= s.ey;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: quiet stretches, random stalls, periodic stalls, long holds
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(10, 80);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= (stall_cnt % 7) < 3;
      default: out_stall <= ($urandom_range(0, 9) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // monitor: compare each vertex word with the oldest prediction
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (vertex_fifo.size() == 0) begin
        $error("unexpected vertex word idx=%0d", out_vertex_index);
        errors++;
      end else begin
        e = vertex_fifo.pop_front();
        if (out_vertex_index !== e.idx) begin
          $error("vertex_index exp %0d got %0d", e.idx, out_vertex_index);
          errors++;
        end
        if (out_vertex_x !== e.x) begin
          $error("vertex_x exp %0d got %0d", e.x, out_vertex_x);
          errors++;
        end
        if (out_vertex_y !== e.y) begin
          $error("vertex_y exp %0d got %0d", e.y, out_vertex_y);
          errors++;
        end
        if (out_coverage !== e.cov) begin
          $error("coverage exp %0d got %0d", e.cov, out_coverage);
          errors++;
        end
        if (out_degenerate !== e.degen) begin
          $error("degenerate exp %0d got %0d", e.degen, out_degenerate);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  function automatic segment_t seg(int sx, int sy, int ex, int ey);
    segment_t s;
    s.sx = CB'(sx); s.sy = CB'(sy); s.ex = CB'(ex); s.ey = CB'(ey);
    return s;
  endfunction

  // append one segment to the send queue
  function automatic void add_seg(segment_t s);
    pending_segs.insert(pending_segs.size(), s);
  endfunction

  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;

  initial begin
    int bx, by, kind;
    // directed: zero length, extremes, sub-pixel, unit, axis, saturation
    add_seg(seg(0, 0, 0, 0));
    add_seg(seg(MAXC, MINC, MAXC, MINC));
    add_seg(seg(MINC, MINC, MAXC, MAXC));
    add_seg(seg(MAXC, MAXC, MINC, MINC));
    add_seg(seg(MINC, MAXC, MAXC, MINC));
    add_seg(seg(MAXC, 0, MINC, 0));
    add_seg(seg(0, MINC, 0, MAXC));
    add_seg(seg(0, 0, 1, 0));
    add_seg(seg(0, 0, 0, -1));
    add_seg(seg(100, 100, 101, 101));
    add_seg(seg(0, 0, 255, 0));
    add_seg(seg(0, 0, 256, 0));
    add_seg(seg(0, 0, 181, 181));
    add_seg(seg(0, 0, 181, 180));
    add_seg(seg(500, -300, 200, -700));
    add_seg(seg(MAXC, MAXC, MAXC - 300, MAXC - 1));
    add_seg(seg(MINC, MINC, MINC + 2, MINC + 900));
    add_seg(seg(MAXC - 3, 0, MAXC, 2));
    add_seg(seg(-1, -1, -1, -1));
    add_seg(seg(0, 0, -3, 7));
    // random: sub-pixel, mid-size, zero-length and full-range segments
    for (int i = 0; i < 240; i++) begin
      bx = $urandom;
      by = $urandom;
      kind = $urandom_range(0, 9);
      if (kind < 3)
        add_seg(seg(bx, by, bx + $urandom_range(0, 510) - 255,
                    by + $urandom_range(0, 510) - 255));
      else if (kind < 6)
        add_seg(seg(bx, by, bx + $urandom_range(0, 200000) - 100000,
                    by + $urandom_range(0, 200000) - 100000));
      else if (kind == 6)
        add_seg(seg(bx, by, bx, by));
      else
        add_seg(seg(bx, by, $urandom, $urandom));
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_segs.size() == 0 && !in_valid && vertex_fifo.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d segments (%0d sub-pixel, %0d zero-length), checked %0d vertex words.",
             segs_sent, short_segs, degen_segs, words_seen);
    if (errors == 0 && vertex_fifo.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/aalve_pkg.sv
design/aa_line_vertex_expand.sv
verif/tb_aa_line_vertex_expand.sv
